FILE: design/ipv4_header_generator_top_assert.svh
// ----------------------------------------------------------------------------
// IPv4 header generator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_GENERATOR_TOP_ASSERT_SVH
`define IPV4_HEADER_GENERATOR_TOP_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define IHG_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define IHG_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that implies another in the next cycle.
`define IHG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ihg_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 header generator package
// Types, constants and register indexes shared by the header generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ihg_pkg;

	localparam int HDR_WORDS = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int IN_DATA_W = 72;
	localparam int WORD_W = 32;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [7:0] VERSION_IHL = 8'h45;
	localparam logic [7:0] SERVICE_TYPE = 8'h00;
	localparam logic [15:0] IDENT_RESET = 16'h0001;
	localparam logic [7:0] TTL_RESET = 8'd64;
	localparam logic [31:0] SOURCE_RESET = 32'h0000_0000;

	localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_ADDR = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TIME_TO_LIVE = 1'b1;

	typedef struct packed {
		logic [15:0] total_length;
		logic [15:0] ident;
		logic [15:0] flags_fragment;
		logic [7:0]  time_to_live;
		logic [7:0]  protocol;
		logic [15:0] checksum;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
	} hdr_t;

endpackage

`default_nettype wire

FILE: design/ipv4_header_generator_top.sv
// ----------------------------------------------------------------------------
// IPv4 header generator
// Requests pass the front register, header queue and registered output stage.
// Each header leaves as five words; new requests queue up while a header is sent.
// Reset clears the queue, output stage and identification counter (to 1).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipv4_header_generator_top #(
	parameter int QUEUE_DEPTH = ihg_pkg::QUEUE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// dest_addr, protocol, flags_fragment, total_length
	input  wire logic [ihg_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// header_word
	output logic [ihg_pkg::WORD_W-1:0]           m_tdata,
	output logic                                 m_tlast,
	input  wire logic                            cfg_we,
	input  wire logic [ihg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ihg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic          push;
	logic          push_ready;
	ihg_pkg::hdr_t push_hdr;
	logic          pop;
	logic          head_valid;
	ihg_pkg::hdr_t head_hdr;

	ihg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_ready (push_ready),
		.push_hdr   (push_hdr)
	);

	ihg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_hdr   (push_hdr),
		.pop        (pop),
		.head_valid (head_valid),
		.head_hdr   (head_hdr)
	);

	ihg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_hdr   (head_hdr),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

FILE: design/ihg_front.sv
// ----------------------------------------------------------------------------
// IPv4 header generator front end
// Accepts requests, assigns the identification and computes the checksum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_header_generator_top_assert.svh"

module ihg_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [ihg_pkg::IN_DATA_W-1:0]      s_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [ihg_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [ihg_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                    push,
	input  wire logic                               push_ready,
	output ihg_pkg::hdr_t                           push_hdr
);

	logic [31:0] source_q;
	logic [7:0]  ttl_q;
	logic [15:0] ident_q;
	logic        valid_s1;
	ihg_pkg::hdr_t hdr_s1;
	logic [16:0] part_s1 [ihg_pkg::HDR_WORDS];
	logic        accept;
	logic [19:0] sum;
	logic [16:0] fold1;
	logic [15:0] fold2;

	assign s_tready = !valid_s1 || push_ready;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= ihg_pkg::SOURCE_RESET;
			ttl_q <= ihg_pkg::TTL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ihg_pkg::CFG_SOURCE_ADDR: source_q <= cfg_data;
				ihg_pkg::CFG_TIME_TO_LIVE: ttl_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= ihg_pkg::IDENT_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				ident_q <= ident_q + 16'd1;
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_s1.dest_addr <= s_tdata[31:0];
			hdr_s1.protocol <= s_tdata[39:32];
			hdr_s1.flags_fragment <= s_tdata[55:40];
			hdr_s1.total_length <= s_tdata[71:56];
			hdr_s1.ident <= ident_q;
			hdr_s1.time_to_live <= ttl_q;
			hdr_s1.source_addr <= source_q;
			hdr_s1.checksum <= 16'h0000;
			part_s1[0] <= {1'b0, ihg_pkg::VERSION_IHL, ihg_pkg::SERVICE_TYPE}
				+ {1'b0, s_tdata[71:56]};
			part_s1[1] <= {1'b0, ident_q} + {1'b0, s_tdata[55:40]};
			part_s1[2] <= {1'b0, ttl_q, s_tdata[39:32]};
			part_s1[3] <= {1'b0, source_q[31:16]} + {1'b0, source_q[15:0]};
			part_s1[4] <= {1'b0, s_tdata[31:16]} + {1'b0, s_tdata[15:0]};
		end
	end

	always_comb begin
		sum = {3'b000, part_s1[0]} + {3'b000, part_s1[1]} + {3'b000, part_s1[2]}
			+ {3'b000, part_s1[3]} + {3'b000, part_s1[4]};
		fold1 = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
		push_hdr = hdr_s1;
		push_hdr.checksum = ~fold2;
	end

	assign push = valid_s1 && push_ready;

	`IHG_ASSERT_NEXT(a_ident_step, accept, ident_q == $past(ident_q) + 16'd1,
		"identification did not advance by one on an accepted item")

endmodule

`default_nettype wire

FILE: design/ihg_queue.sv
// ----------------------------------------------------------------------------
// IPv4 header generator header queue
// Short first-in first-out store of finished headers between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_header_generator_top_assert.svh"

module ihg_queue #(
	parameter int DEPTH = ihg_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               push_ready,
	input  wire ihg_pkg::hdr_t push_hdr,
	input  wire logic          pop,
	output logic               head_valid,
	output ihg_pkg::hdr_t      head_hdr
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	ihg_pkg::hdr_t store_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign push_ready = count_q != FULL_COUNT;
	assign head_valid = count_q != '0;
	assign head_hdr = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_hdr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: ;
			endcase
		end
	end

	`IHG_ASSERT_ALWAYS(a_count_range, count_q <= FULL_COUNT,
		"queue fill count beyond its depth")
	`IHG_ASSERT_IMPLY(a_no_pop_empty, pop, count_q != '0,
		"header taken from an empty queue")

endmodule

`default_nettype wire

FILE: design/ihg_back.sv
// ----------------------------------------------------------------------------
// IPv4 header generator back end
// Sends the queued header as five words through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_header_generator_top_assert.svh"

module ihg_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        head_valid,
	input  wire ihg_pkg::hdr_t               head_hdr,
	output logic                             pop,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [ihg_pkg::WORD_W-1:0]       m_tdata,
	output logic                             m_tlast
);

	localparam logic [2:0] LAST_IDX = 3'(ihg_pkg::HDR_WORDS - 1);

	logic [2:0]  word_idx_q;
	logic        out_load;
	logic        is_last;
	logic [31:0] word;

	assign out_load = !m_tvalid || m_tready;
	assign is_last = word_idx_q == LAST_IDX;
	assign pop = out_load && head_valid && is_last;

	always_comb begin
		case (word_idx_q)
			3'd0: word = {ihg_pkg::VERSION_IHL, ihg_pkg::SERVICE_TYPE, head_hdr.total_length};
			3'd1: word = {head_hdr.ident, head_hdr.flags_fragment};
			3'd2: word = {head_hdr.time_to_live, head_hdr.protocol, head_hdr.checksum};
			3'd3: word = head_hdr.source_addr;
			default: word = head_hdr.dest_addr;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			word_idx_q <= '0;
		end else if (out_load) begin
			m_tvalid <= head_valid;
			if (head_valid) begin
				word_idx_q <= is_last ? 3'd0 : word_idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && head_valid) begin
			m_tdata <= word;
			m_tlast <= is_last;
		end
	end

	`IHG_ASSERT_IMPLY(a_head_held, word_idx_q != 3'd0, head_valid,
		"queue head lost in the middle of a header")
	`IHG_ASSERT_ALWAYS(a_idx_range, word_idx_q <= LAST_IDX,
		"header word index out of range")

endmodule

`default_nettype wire

FILE: sim/tb_ipv4_header_generator_top.sv
// ----------------------------------------------------------------------------
// IPv4 header generator testbench
// Sends header requests under several source address and TTL settings and with
// random gaps on both streams, and predicts every header word, identification
// number and checksum. Each output word and its last flag is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ipv4_header_generator_top;

	localparam int LIMIT_CYCLES = 20_000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_ITEMS = 22;
	localparam int DIRECTED_COUNT = 12;

	typedef struct packed {
		logic [15:0] total_length;
		logic [15:0] flags_fragment;
		logic [7:0]  protocol;
		logic [31:0] dest_addr;
	} request_t;

	typedef struct packed {
		logic [ihg_pkg::WORD_W-1:0] word;
		logic                       last;
	} header_word_t;

	typedef struct {
		request_t    req;
		bit          typed;
		logic [31:0] word1;
		logic [31:0] word2;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ihg_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [ihg_pkg::WORD_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [ihg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [ihg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [31:0] source_model = ihg_pkg::SOURCE_RESET;
	logic [7:0] ttl_model = ihg_pkg::TTL_RESET;
	logic [15:0] ident_model = ihg_pkg::IDENT_RESET;
	header_word_t header_words_due [$];

	bit typed_pending = 1'b0;
	logic [31:0] typed_word1 = '0;
	logic [31:0] typed_word2 = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	ipv4_header_generator_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void predict_header(input request_t req);
		logic [ihg_pkg::WORD_W-1:0] w [ihg_pkg::HDR_WORDS];
		logic [19:0] acc;
		header_word_t entry;
		w[0] = {ihg_pkg::VERSION_IHL, ihg_pkg::SERVICE_TYPE, req.total_length};
		w[1] = {ident_model, req.flags_fragment};
		w[2] = {ttl_model, req.protocol, 16'h0000};
		w[3] = source_model;
		w[4] = req.dest_addr;
		acc = '0;
		for (int i = 0; i < ihg_pkg::HDR_WORDS; i++) begin
			acc = acc + w[i][31:16] + w[i][15:0];
		end
		// Two folds are enough for the sum of ten 16-bit words.
		acc = acc[15:0] + acc[19:16];
		acc = acc[15:0] + acc[19:16];
		w[2][15:0] = ~acc[15:0];
		if (typed_pending) begin
			w[1] = typed_word1;
			w[2] = typed_word2;
		end
		ident_model = ident_model + 16'd1;
		for (int i = 0; i < ihg_pkg::HDR_WORDS; i++) begin
			entry.word = w[i];
			entry.last = (i == ihg_pkg::HDR_WORDS - 1);
			header_words_due.push_back(entry);
		end
	endfunction

	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : monitor
		header_word_t due;
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: run timed out", $time);
			$display("tb_ipv4_header_generator_top: FAIL");
			$finish;
		end else if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					ihg_pkg::CFG_SOURCE_ADDR: source_model = cfg_data;
					ihg_pkg::CFG_TIME_TO_LIVE: ttl_model = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predict_header(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				if (header_words_due.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected item, expected none, got word %h last %b",
						$time, m_tdata, m_tlast);
				end else begin
					due = header_words_due.pop_front();
					if (m_tdata !== due.word) begin
						mismatch_count++;
						$display("%0t: header word mismatch, expected %h, got %h",
							$time, due.word, m_tdata);
					end
					if (m_tlast !== due.last) begin
						mismatch_count++;
						$display("%0t: last flag mismatch, expected %b, got %b",
							$time, due.last, m_tlast);
					end
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance with
	// the valid still high.
	task automatic send_request(input request_t req);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = req;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		while (header_words_due.size() != 0) @(negedge clk);
	endtask

	task automatic write_register(input logic [ihg_pkg::CFG_INDEX_W-1:0] index,
			input logic [ihg_pkg::CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [31:0] source, input logic [7:0] ttl,
			input int send_pct, input int recv_pct, input int count);
		logic [31:0] noise;
		request_t req;
		s_tvalid = 1'b0;
		wait_drain();
		noise = $urandom;
		write_register(ihg_pkg::CFG_SOURCE_ADDR, source);
		write_register(ihg_pkg::CFG_TIME_TO_LIVE, {noise[31:8], ttl});
		cfg_we = 1'b0;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int n = 0; n < count; n++) begin
			req.dest_addr = $urandom;
			req.protocol = 8'($urandom_range(0, 255));
			req.flags_fragment = 16'($urandom_range(0, 65535));
			req.total_length = 16'($urandom_range(0, 65535));
			send_request(req);
		end
	endtask

	initial begin : stimulus
		directed_row_t rows [DIRECTED_COUNT];
		// Rows: {total_length, flags_fragment, protocol, dest_addr}, typed, word 1, word 2.
		rows[0] = '{'{16'h0000, 16'h0000, 8'h00, 32'h0000_0000}, 1'b1,
			32'h0001_0000, 32'h4000_7AFE};
		rows[1] = '{'{16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, 1'b1,
			32'h0002_FFFF, 32'h40FF_79FE};
		rows[2] = '{'{16'd84, 16'h4000, 8'd1, 32'h0A00_0001}, 1'b0, '0, '0};
		rows[3] = '{'{16'd1500, 16'h2000, 8'd6, 32'hC0A8_0101}, 1'b0, '0, '0};
		rows[4] = '{'{16'd20, 16'h1FFF, 8'd17, 32'h8000_0000}, 1'b0, '0, '0};
		rows[5] = '{'{16'd19, 16'h8000, 8'h80, 32'h0000_0001}, 1'b0, '0, '0};
		rows[6] = '{'{16'h8000, 16'h0001, 8'h7F, 32'h7FFF_FFFF}, 1'b0, '0, '0};
		rows[7] = '{'{16'hAAAA, 16'hAAAA, 8'hAA, 32'hAAAA_AAAA}, 1'b0, '0, '0};
		rows[8] = '{'{16'h5555, 16'h5555, 8'h55, 32'h5555_5555}, 1'b0, '0, '0};
		rows[9] = '{'{16'hFFFF, 16'h0000, 8'h00, 32'hFFFF_FFFF}, 1'b0, '0, '0};
		rows[10] = '{'{16'd1, 16'h6000, 8'd2, 32'hE000_0001}, 1'b0, '0, '0};
		rows[11] = '{'{16'h0000, 16'hFFFF, 8'hFF, 32'h0000_0000}, 1'b0, '0, '0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 24;
		recv_stall_pct = 24;
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			typed_pending = rows[i].typed;
			typed_word1 = rows[i].word1;
			typed_word2 = rows[i].word2;
			send_request(rows[i].req);
		end
		typed_pending = 1'b0;

		run_phase(32'hFFFF_FFFF, 8'hFF, 0, 0, PHASE_ITEMS);
		run_phase(32'h0000_0000, 8'h00, 52, 0, PHASE_ITEMS);
		run_phase($urandom, 8'($urandom_range(0, 255)), 0, 52, PHASE_ITEMS);
		run_phase($urandom, 8'($urandom_range(0, 255)), 24, 24, PHASE_ITEMS);

		s_tvalid = 1'b0;
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && header_words_due.size() == 0) begin
			$display("tb_ipv4_header_generator_top: PASS");
		end else begin
			$display("tb_ipv4_header_generator_top: FAIL");
		end
		$finish;
	end

endmodule
